// ===== design/cau_pkg.sv =====
// Shared types and constants for the complex arithmetic unit.
`timescale 1ns / 1ps

package cau_pkg;

   // Operand format: signed Q8.8.
   localparam int DATA_W = 16;
   localparam int FRAC_W = 8;

   // Exact product sums need one bit more than a product.
   localparam int SUM_W  = 2 * DATA_W + 1;
   // Magnitude of a product sum and of the divisor norm.
   localparam int MAG_W  = 2 * DATA_W;
   localparam int DEN_W  = 2 * DATA_W;
   // Quotient bits that are worked out; larger quotients saturate anyway.
   localparam int QUO_W  = DATA_W + 1;
   // Divide numerator, the magnitude shifted up by the fraction bits.
   localparam int NUM_W  = MAG_W + FRAC_W;
   // Width for the quotient range check.
   localparam int CMP_W  = DEN_W + QUO_W;
   // Pipeline depth from input register to output register.
   localparam int LATENCY = QUO_W + 4;

   // Saturation limits, as magnitudes.
   localparam logic [NUM_W-1:0] SAT_POS = (NUM_W'(1) << (DATA_W - 1)) - NUM_W'(1);
   localparam logic [NUM_W-1:0] SAT_NEG = NUM_W'(1) << (DATA_W - 1);

   typedef enum logic [1:0] {
      KIND_ADD  = 2'd0,
      KIND_MUL  = 2'd1,
      KIND_DIV  = 2'd2,
      KIND_CONJ = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type                   kind;
      logic signed [DATA_W-1:0]   a_real;
      logic signed [DATA_W-1:0]   a_imag;
      logic signed [DATA_W-1:0]   b_real;
      logic signed [DATA_W-1:0]   b_imag;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]   res_real;
      logic signed [DATA_W-1:0]   res_imag;
      logic                       overflow;
      logic                       div_zero;
   } rsp_type;

   // One item in flight after the products are summed.
   typedef struct packed {
      kind_type                   kind;
      logic                       neg_re;
      logic                       neg_im;
      logic                       dz;
      logic                       big_re;
      logic                       big_im;
      logic [NUM_W-1:0]           num_re;
      logic [NUM_W-1:0]           num_im;
      logic [DEN_W-1:0]           den;
      logic [DEN_W-1:0]           rem_re;
      logic [DEN_W-1:0]           rem_im;
      logic [QUO_W-1:0]           q_re;
      logic [QUO_W-1:0]           q_im;
   } work_type;

endpackage

// ===== design/cau_mult.sv =====
// Product stage and sum stage: products, sums and sign-magnitude split.
`timescale 1ns / 1ps

module cau_mult (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  cau_pkg::req_type in_item,
   output logic             out_valid,
   output cau_pkg::work_type out_work
);
   import cau_pkg::*;

   logic                     a_valid_ff;
   kind_type                 a_kind_ff;
   logic signed [MAG_W-1:0]  p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_bb_ff, p_cc_ff;
   logic signed [DATA_W:0]   sum_re_ff, sum_im_ff;
   logic signed [DATA_W:0]   sum_re_in, sum_im_in;

   logic                     b_valid_ff;
   work_type                 work_ff, work_in;

   logic signed [SUM_W-1:0]  sel_re, sel_im;
   logic [MAG_W-1:0]         mag_re, mag_im;
   logic [DEN_W-1:0]         den;

   // Add and conjugate need no multiplier; form them beside the products.
   always_comb begin
      if (in_item.kind == KIND_CONJ) begin
         sum_re_in = (DATA_W + 1)'(in_item.a_real);
         sum_im_in = -(DATA_W + 1)'(in_item.a_imag);
      end else begin
         sum_re_in = (DATA_W + 1)'(in_item.a_real) + (DATA_W + 1)'(in_item.b_real);
         sum_im_in = (DATA_W + 1)'(in_item.a_imag) + (DATA_W + 1)'(in_item.b_imag);
      end
   end

   // Product register.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= in_valid;
      end
      if (adv) begin
         a_kind_ff <= in_item.kind;
         p_rr_ff   <= in_item.a_real * in_item.b_real;
         p_ii_ff   <= in_item.a_imag * in_item.b_imag;
         p_ri_ff   <= in_item.a_real * in_item.b_imag;
         p_ir_ff   <= in_item.a_imag * in_item.b_real;
         p_bb_ff   <= in_item.b_real * in_item.b_real;
         p_cc_ff   <= in_item.b_imag * in_item.b_imag;
         sum_re_ff <= sum_re_in;
         sum_im_ff <= sum_im_in;
      end
   end

   // Select the exact signed result per kind and split it into sign and magnitude.
   always_comb begin
      den = DEN_W'($unsigned(p_bb_ff)) + DEN_W'($unsigned(p_cc_ff));
      case (a_kind_ff)
         KIND_MUL: begin
            sel_re = SUM_W'(p_rr_ff) - SUM_W'(p_ii_ff);
            sel_im = SUM_W'(p_ri_ff) + SUM_W'(p_ir_ff);
         end
         KIND_DIV: begin
            sel_re = SUM_W'(p_rr_ff) + SUM_W'(p_ii_ff);
            sel_im = SUM_W'(p_ir_ff) - SUM_W'(p_ri_ff);
         end
         default: begin
            sel_re = SUM_W'(sum_re_ff);
            sel_im = SUM_W'(sum_im_ff);
         end
      endcase
      mag_re = sel_re[SUM_W-1] ? MAG_W'(-sel_re) : MAG_W'(sel_re);
      mag_im = sel_im[SUM_W-1] ? MAG_W'(-sel_im) : MAG_W'(sel_im);

      work_in        = '0;
      work_in.kind   = a_kind_ff;
      work_in.neg_re = sel_re[SUM_W-1];
      work_in.neg_im = sel_im[SUM_W-1];
      work_in.den    = den;
      work_in.dz     = (a_kind_ff == KIND_DIV) && (den == '0);
      case (a_kind_ff)
         KIND_MUL: begin
            work_in.num_re = NUM_W'(mag_re >> FRAC_W);
            work_in.num_im = NUM_W'(mag_im >> FRAC_W);
         end
         KIND_DIV: begin
            work_in.num_re = NUM_W'(mag_re) << FRAC_W;
            work_in.num_im = NUM_W'(mag_im) << FRAC_W;
         end
         default: begin
            work_in.num_re = NUM_W'(mag_re);
            work_in.num_im = NUM_W'(mag_im);
         end
      endcase
   end

   // Sum register.
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= a_valid_ff;
      end
      if (adv) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_work  = work_ff;

endmodule

// ===== design/cau_div.sv =====
// Pipelined restoring divider, one quotient bit per stage for both parts.
`timescale 1ns / 1ps

module cau_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  cau_pkg::work_type in_work,
   output logic              out_valid,
   output cau_pkg::work_type out_work
);
   import cau_pkg::*;

   logic     valid_ff [0:QUO_W];
   work_type work_ff  [0:QUO_W];
   work_type setup_in;

   // Quotients of 2^QUO_W or more are flagged; the rest start from the top bits.
   always_comb begin
      setup_in        = in_work;
      setup_in.big_re = CMP_W'(in_work.num_re) >= (CMP_W'(in_work.den) << QUO_W);
      setup_in.big_im = CMP_W'(in_work.num_im) >= (CMP_W'(in_work.den) << QUO_W);
      setup_in.rem_re = DEN_W'(in_work.num_re >> QUO_W);
      setup_in.rem_im = DEN_W'(in_work.num_im >> QUO_W);
      setup_in.q_re   = '0;
      setup_in.q_im   = '0;
   end

   // Setup register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= in_valid;
      end
      if (adv) begin
         work_ff[0] <= setup_in;
      end
   end

   // One stage per quotient bit, most significant first.
   for (genvar k = 0; k < QUO_W; k++) begin : g_bit
      localparam int BIT = QUO_W - 1 - k;
      logic [DEN_W:0] shift_re, shift_im;
      logic           ge_re, ge_im;
      work_type       step_in;

      always_comb begin
         step_in  = work_ff[k];
         shift_re = {work_ff[k].rem_re, work_ff[k].num_re[BIT]};
         shift_im = {work_ff[k].rem_im, work_ff[k].num_im[BIT]};
         ge_re    = shift_re >= {1'b0, work_ff[k].den};
         ge_im    = shift_im >= {1'b0, work_ff[k].den};
         step_in.rem_re = ge_re ? DEN_W'(shift_re - {1'b0, work_ff[k].den})
                                : DEN_W'(shift_re);
         step_in.rem_im = ge_im ? DEN_W'(shift_im - {1'b0, work_ff[k].den})
                                : DEN_W'(shift_im);
         step_in.q_re[BIT] = ge_re;
         step_in.q_im[BIT] = ge_im;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (adv) begin
            valid_ff[k+1] <= valid_ff[k];
         end
         if (adv) begin
            work_ff[k+1] <= step_in;
         end
      end
   end

   assign out_valid = valid_ff[QUO_W];
   assign out_work  = work_ff[QUO_W];

endmodule

// ===== design/cau_sat.sv =====
// Result selection, saturation and the output register.
`timescale 1ns / 1ps

module cau_sat (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  cau_pkg::work_type in_work,
   output logic              out_valid,
   output cau_pkg::rsp_type  out_item
);
   import cau_pkg::*;

   logic             valid_ff;
   rsp_type          item_ff, item_in;
   logic [NUM_W-1:0] mag_re, mag_im, lim_re, lim_im, clip_re, clip_im;

   // Pick the magnitude per kind, then clamp it to the signed range.
   always_comb begin
      if (in_work.kind == KIND_DIV) begin
         if (in_work.dz) begin
            mag_re = '0;
            mag_im = '0;
         end else begin
            mag_re = in_work.big_re ? '1 : NUM_W'(in_work.q_re);
            mag_im = in_work.big_im ? '1 : NUM_W'(in_work.q_im);
         end
      end else begin
         mag_re = in_work.num_re;
         mag_im = in_work.num_im;
      end
      lim_re  = in_work.neg_re ? SAT_NEG : SAT_POS;
      lim_im  = in_work.neg_im ? SAT_NEG : SAT_POS;
      clip_re = (mag_re > lim_re) ? lim_re : mag_re;
      clip_im = (mag_im > lim_im) ? lim_im : mag_im;

      item_in.res_real = in_work.neg_re ? DATA_W'(-clip_re) : DATA_W'(clip_re);
      item_in.res_imag = in_work.neg_im ? DATA_W'(-clip_im) : DATA_W'(clip_im);
      item_in.overflow = (mag_re > lim_re) || (mag_im > lim_im);
      item_in.div_zero = in_work.dz;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ===== design/complex_arithmetic_unit.sv =====
// Complex arithmetic unit: add, multiply, divide and conjugate on Q8.8 operands.
// The path from input to output register runs through one product stage, one sum
// stage, one divide setup stage, 17 quotient-bit stages and the output register.
// Throughput is one item per cycle while the output is not stalled; every kind takes the same path through the divider.
// A stalled valid output holds the whole pipeline, so req_stall is rsp_stall gated by rsp_valid.
// Synchronous reset clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps

module complex_arithmetic_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cau_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cau_pkg::rsp_type rsp_item
);
   import cau_pkg::*;

   logic     adv;
   logic     mult_valid, div_valid;
   work_type mult_work, div_work;

   // The pipeline moves whenever the output register is free or being taken.
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   cau_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_item   (req_item),
      .out_valid (mult_valid),
      .out_work  (mult_work)
   );

   cau_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (mult_valid),
      .in_work   (mult_work),
      .out_valid (div_valid),
      .out_work  (div_work)
   );

   cau_sat u_sat (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (div_valid),
      .in_work   (div_work),
      .out_valid (rsp_valid),
      .out_item  (rsp_item)
   );

endmodule

// ===== design/cau_checker.sv =====
// Port-level checks for the complex arithmetic unit, bound to the top level.
`timescale 1ns / 1ps

module cau_props (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input cau_pkg::req_type req_item,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input cau_pkg::rsp_type rsp_item
);
   import cau_pkg::*;

   // A stalled result item stays and holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result item changed while stalled");

   // A divide by zero gives a zero result and no overflow.
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.div_zero |->
         rsp_item.res_real == '0 && rsp_item.res_imag == '0 && !rsp_item.overflow)
      else $error("divide by zero item carries a nonzero result");

   // A blocked output holds the input side too.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input accepted while output is blocked");

   // No result item right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item present after reset");

endmodule

bind complex_arithmetic_unit cau_props u_cau_props (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);
